/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the regularizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the expression in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle implication");

// The condition implies the expression in the following cycle.
`define ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hdl/enr_pkg.sv */
// ----------------------------------------------------------------------------
// Elastic-net regularizer package
// Field widths, fixed-point formats, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package enr_pkg;

  // Weight width default and fixed-point formats.
  localparam int WEIGHT_BITS_DEFAULT = 16;
  localparam int FRAC_BITS           = 12;
  localparam int COEF_BITS           = 16;
  localparam int SCALE_BITS          = 17;
  localparam int SCALE_FRAC_BITS     = 16;

  // Running sums and result widths.
  localparam int ABS_SUM_BITS = 40;
  localparam int SQ_SUM_BITS  = 56;
  localparam int GRAD_BITS    = 33;
  localparam int LOSS_BITS    = 63;

  // Loss multiply split into partial products.
  localparam int ABS_SPLIT     = 20;
  localparam int SQ_SPLIT      = 28;
  localparam int P_ABS_BITS    = COEF_BITS + ABS_SPLIT;
  localparam int P_SQ_BITS     = COEF_BITS + SQ_SPLIT;
  localparam int T1_BITS       = COEF_BITS + ABS_SUM_BITS;
  localparam int SQ_PROD_BITS  = COEF_BITS + SQ_SUM_BITS;
  localparam int L2_LOSS_SHIFT = 13;
  localparam int T2_BITS       = SQ_PROD_BITS - L2_LOSS_SHIFT;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = SCALE_BITS;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_L1_STRENGTH = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_L2_STRENGTH = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DECAY_SCALE = 2'd2;

  // Decay multiplier of 1.0 in Q1.16.
  localparam logic [SCALE_BITS-1:0] DECAY_SCALE_RESET = 17'h10000;

  // Control from the pipeline to the accumulator.
  typedef struct packed {
    logic step;
    logic last;
  } acc_ctl_t;

  // Running sums including the current item, with the sticky flag.
  typedef struct packed {
    logic [ABS_SUM_BITS-1:0] abs_sum;
    logic [SQ_SUM_BITS-1:0]  sq_sum;
    logic                    sat;
  } acc_sums_t;

endpackage

`default_nettype wire

/* hdl/enr_in_if.sv */
// ----------------------------------------------------------------------------
// Weight input channel
// Valid/ready channel carrying one weight item and its last-of-set flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface enr_in_if #(
  parameter int WEIGHT_BITS = enr_pkg::WEIGHT_BITS_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [WEIGHT_BITS-1:0] weight_value;
  logic                          set_last;

  modport source (output valid, output weight_value, output set_last, input ready);
  modport sink   (input valid, input weight_value, input set_last, output ready);
endinterface

`default_nettype wire

/* hdl/enr_out_if.sv */
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one result item per weight item.
// ----------------------------------------------------------------------------
`default_nettype none

interface enr_out_if #(
  parameter int WEIGHT_BITS = enr_pkg::WEIGHT_BITS_DEFAULT
);
  logic                                 valid;
  logic                                 ready;
  logic signed [enr_pkg::GRAD_BITS-1:0] gradient;
  logic signed [WEIGHT_BITS-1:0]        decayed_weight;
  logic [enr_pkg::LOSS_BITS-1:0]        set_loss;
  logic                                 loss_valid;
  logic                                 sum_saturated;

  modport source (
    output valid, output gradient, output decayed_weight, output set_loss,
    output loss_valid, output sum_saturated, input ready
  );
  modport sink (
    input valid, input gradient, input decayed_weight, input set_loss,
    input loss_valid, input sum_saturated, output ready
  );
endinterface

`default_nettype wire

/* hdl/enr_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface enr_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [enr_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [enr_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/enr_accum.sv */
// ----------------------------------------------------------------------------
// Running sum accumulator
// Saturating sums of |w| and w^2 with a sticky saturation flag per set.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module enr_accum #(
  parameter int WEIGHT_BITS = enr_pkg::WEIGHT_BITS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire enr_pkg::acc_ctl_t          ctl,
  input  wire logic [WEIGHT_BITS-1:0]     mag,
  input  wire logic [2*WEIGHT_BITS-1:0]   mag_sq,
  output enr_pkg::acc_sums_t              sums
);

  localparam int ABW = enr_pkg::ABS_SUM_BITS;
  localparam int SQB = enr_pkg::SQ_SUM_BITS;
  localparam int ABS_W = ABW + 1;
  localparam int SQ_W = ((2 * WEIGHT_BITS > SQB) ? 2 * WEIGHT_BITS : SQB) + 1;
  localparam logic [ABW-1:0] ABS_CAP = '1;
  localparam logic [SQB-1:0] SQ_CAP  = '1;

  logic [ABW-1:0]   abs_sum;
  logic [SQB-1:0]   sq_sum;
  logic             sat_flag;
  logic [ABS_W-1:0] abs_ext;
  logic [SQ_W-1:0]  sq_ext;
  logic             abs_ovf;
  logic             sq_ovf;

  // Widened adds; a carry past the cap means the sum holds at all ones.
  assign abs_ext = {1'b0, abs_sum} + ABS_W'(mag);
  assign sq_ext  = SQ_W'(sq_sum) + SQ_W'(mag_sq);
  assign abs_ovf = abs_ext > ABS_W'(ABS_CAP);
  assign sq_ovf  = sq_ext > SQ_W'(SQ_CAP);

  always_comb begin
    sums.abs_sum = abs_ovf ? ABS_CAP : abs_ext[ABW-1:0];
    sums.sq_sum  = sq_ovf ? SQ_CAP : sq_ext[SQB-1:0];
    sums.sat     = sat_flag | abs_ovf | sq_ovf;
  end

  // The sums advance once per item and clear after the last item of a set.
  always_ff @(posedge clk) begin
    if (rst) begin
      abs_sum  <= '0;
      sq_sum   <= '0;
      sat_flag <= 1'b0;
    end else if (ctl.step) begin
      if (ctl.last) begin
        abs_sum  <= '0;
        sq_sum   <= '0;
        sat_flag <= 1'b0;
      end else begin
        abs_sum  <= sums.abs_sum;
        sq_sum   <= sums.sq_sum;
        sat_flag <= sums.sat;
      end
    end
  end

  `ASSERT_NEXT(a_clear_after_last, clk, rst, ctl.step && ctl.last, abs_sum == '0 && sq_sum == '0 && !sat_flag)
  `ASSERT_NEXT(a_sums_grow, clk, rst, ctl.step && !ctl.last, abs_sum >= $past(abs_sum) && sq_sum >= $past(sq_sum))
  `ASSERT_NEXT(a_hold_when_idle, clk, rst, !ctl.step, $stable(abs_sum) && $stable(sq_sum))

endmodule

`default_nettype wire

/* hdl/elastic_net_regularizer_stream.sv */
// ----------------------------------------------------------------------------
// Elastic-net regularizer stream
// Path: an accepted weight item passes through registers s1 to s6 to its result.
// Throughput: one item per cycle while results.ready is high, through a six-register
// elastic pipeline; the loss multiplies are split into partial products over two stages.
// Reset: rst clears the pipeline, the running sums and the saturation flag,
// and sets l1/l2 strength to 0 and the decay scale to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module elastic_net_regularizer_stream #(
  parameter int WEIGHT_BITS = enr_pkg::WEIGHT_BITS_DEFAULT
) (
  input wire logic  clk,
  input wire logic  rst,
  enr_cfg_if.sink   cfg,
  enr_in_if.sink    weights,
  enr_out_if.source results
);

  localparam int CB   = enr_pkg::COEF_BITS;
  localparam int SB   = enr_pkg::SCALE_BITS;
  localparam int SFB  = enr_pkg::SCALE_FRAC_BITS;
  localparam int FB   = enr_pkg::FRAC_BITS;
  localparam int GB   = enr_pkg::GRAD_BITS;
  localparam int LB   = enr_pkg::LOSS_BITS;
  localparam int ABW  = enr_pkg::ABS_SUM_BITS;
  localparam int SQB  = enr_pkg::SQ_SUM_BITS;
  localparam int ASP  = enr_pkg::ABS_SPLIT;
  localparam int SSP  = enr_pkg::SQ_SPLIT;
  localparam int PAW  = enr_pkg::P_ABS_BITS;
  localparam int PSW  = enr_pkg::P_SQ_BITS;
  localparam int T1W  = enr_pkg::T1_BITS;
  localparam int SQPW = enr_pkg::SQ_PROD_BITS;
  localparam int T2W  = enr_pkg::T2_BITS;
  localparam int L2S  = enr_pkg::L2_LOSS_SHIFT;
  localparam int GPW  = WEIGHT_BITS + SB;
  localparam int MSW  = 2 * WEIGHT_BITS;
  localparam int GW   = (WEIGHT_BITS + SB + 1 > GB + 1) ? WEIGHT_BITS + SB + 1 : GB + 1;
  localparam int LSW  = LB + 1;

  localparam logic signed [GW-1:0] GRAD_HI = {{(GW-GB+1){1'b0}}, {(GB-1){1'b1}}};
  localparam logic signed [GW-1:0] GRAD_LO = ~GRAD_HI;
  localparam logic [WEIGHT_BITS:0] DMAG_POS_MAX = {2'b00, {(WEIGHT_BITS-1){1'b1}}};
  localparam logic [WEIGHT_BITS:0] DMAG_NEG_MAX = {2'b01, {(WEIGHT_BITS-1){1'b0}}};
  localparam logic [LSW-1:0] LOSS_CAP = {1'b0, {LB{1'b1}}};

  // Configuration registers.
  logic [CB-1:0] l1_strength;
  logic [CB-1:0] l2_strength;
  logic [SB-1:0] decay_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      l1_strength <= '0;
      l2_strength <= '0;
      decay_scale <= enr_pkg::DECAY_SCALE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        enr_pkg::CFG_L1_STRENGTH: l1_strength <= cfg.data[CB-1:0];
        enr_pkg::CFG_L2_STRENGTH: l2_strength <= cfg.data[CB-1:0];
        enr_pkg::CFG_DECAY_SCALE: decay_scale <= cfg.data[SB-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  // Stage valids and the elastic ready chain; a stage loads when it is
  // empty or its item moves on.
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid, s6_valid;
  logic s1_ready, s2_ready, s3_ready, s4_ready, s5_ready, s6_ready;

  assign s6_ready = !s6_valid || results.ready;
  assign s5_ready = !s5_valid || s6_ready;
  assign s4_ready = !s4_valid || s5_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign weights.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= weights.valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (s5_ready) s5_valid <= s4_valid;
      if (s6_ready) s6_valid <= s5_valid;
    end
  end

  // Stage 1: input register.
  logic signed [WEIGHT_BITS-1:0] s1_weight;
  logic                          s1_last;

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_weight <= weights.weight_value;
      s1_last   <= weights.set_last;
    end
  end

  // Magnitude and the three independent products of the weight.
  logic                          s1_neg;
  logic                          s1_zero;
  logic [WEIGHT_BITS-1:0]        s1_mag;
  logic signed [GPW-1:0]         s1_grad_prod;
  logic [GPW-1:0]                s1_decay_prod;
  logic [2*WEIGHT_BITS-1:0]      s1_mag_sq;

  assign s1_neg        = s1_weight[WEIGHT_BITS-1];
  assign s1_zero       = s1_weight == '0;
  assign s1_mag        = s1_neg ? (~s1_weight + 1'b1) : s1_weight;
  assign s1_grad_prod  = GPW'($signed({1'b0, l2_strength})) * GPW'(s1_weight);
  assign s1_decay_prod = GPW'(s1_mag) * GPW'(decay_scale);
  assign s1_mag_sq     = MSW'(s1_mag) * MSW'(s1_mag);

  // Stage 2: products registered.
  logic                          s2_last;
  logic                          s2_neg;
  logic                          s2_zero;
  logic [WEIGHT_BITS-1:0]        s2_mag;
  logic signed [GPW-1:0]         s2_grad_prod;
  logic [GPW-1:0]                s2_decay_prod;
  logic [2*WEIGHT_BITS-1:0]      s2_mag_sq;

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_last       <= s1_last;
      s2_neg        <= s1_neg;
      s2_zero       <= s1_zero;
      s2_mag        <= s1_mag;
      s2_grad_prod  <= s1_grad_prod;
      s2_decay_prod <= s1_decay_prod;
      s2_mag_sq     <= s1_mag_sq;
    end
  end

  // Gradient: add the signed L1 term to the L2 product, then clamp.
  logic signed [GW-1:0]        s2_grad_base;
  logic signed [GW-1:0]        s2_l1_term;
  logic signed [GW-1:0]        s2_grad_ext;
  logic signed [GB-1:0]        s2_gradient;

  assign s2_grad_base = GW'(s2_grad_prod);
  assign s2_l1_term   = $signed(GW'({l1_strength, {FB{1'b0}}}));

  always_comb begin
    if (s2_zero) begin
      s2_grad_ext = s2_grad_base;
    end else if (s2_neg) begin
      s2_grad_ext = s2_grad_base - s2_l1_term;
    end else begin
      s2_grad_ext = s2_grad_base + s2_l1_term;
    end
    if (s2_grad_ext > GRAD_HI) begin
      s2_gradient = GRAD_HI[GB-1:0];
    end else if (s2_grad_ext < GRAD_LO) begin
      s2_gradient = GRAD_LO[GB-1:0];
    end else begin
      s2_gradient = s2_grad_ext[GB-1:0];
    end
  end

  // Decayed weight: the magnitude is truncated, clamped, then the sign restored.
  logic [WEIGHT_BITS:0]          s2_dmag;
  logic [WEIGHT_BITS:0]          s2_dmag_lim;
  logic [WEIGHT_BITS:0]          s2_dneg;
  logic signed [WEIGHT_BITS-1:0] s2_decayed;

  assign s2_dmag = s2_decay_prod[WEIGHT_BITS+SFB:SFB];

  always_comb begin
    s2_dmag_lim = s2_dmag;
    s2_dneg     = '0;
    if (s2_neg) begin
      if (s2_dmag > DMAG_NEG_MAX) begin
        s2_dmag_lim = DMAG_NEG_MAX;
      end
      s2_dneg    = ~s2_dmag_lim + 1'b1;
      s2_decayed = s2_dneg[WEIGHT_BITS-1:0];
    end else if (s2_dmag > DMAG_POS_MAX) begin
      s2_decayed = DMAG_POS_MAX[WEIGHT_BITS-1:0];
    end else begin
      s2_decayed = s2_dmag[WEIGHT_BITS-1:0];
    end
  end

  // Running sums advance as the item moves into stage 3.
  enr_pkg::acc_ctl_t  acc_ctl;
  enr_pkg::acc_sums_t acc_sums;

  always_comb begin
    acc_ctl.step = s2_valid && s3_ready;
    acc_ctl.last = s2_last;
  end

  enr_accum #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctl    (acc_ctl),
    .mag    (s2_mag),
    .mag_sq (s2_mag_sq),
    .sums   (acc_sums)
  );

  // Stage 3: per-item results and a snapshot of the sums.
  logic                          s3_last;
  logic signed [GB-1:0]          s3_gradient;
  logic signed [WEIGHT_BITS-1:0] s3_decayed;
  enr_pkg::acc_sums_t            s3_sums;

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      s3_last     <= s2_last;
      s3_gradient <= s2_gradient;
      s3_decayed  <= s2_decayed;
      s3_sums     <= acc_sums;
    end
  end

  // Loss partial products on split halves of the sums.
  logic [PAW-1:0] s3_p_abs_hi;
  logic [PAW-1:0] s3_p_abs_lo;
  logic [PSW-1:0] s3_p_sq_hi;
  logic [PSW-1:0] s3_p_sq_lo;

  assign s3_p_abs_hi = PAW'(l1_strength) * PAW'(s3_sums.abs_sum[ABW-1:ASP]);
  assign s3_p_abs_lo = PAW'(l1_strength) * PAW'(s3_sums.abs_sum[ASP-1:0]);
  assign s3_p_sq_hi  = PSW'(l2_strength) * PSW'(s3_sums.sq_sum[SQB-1:SSP]);
  assign s3_p_sq_lo  = PSW'(l2_strength) * PSW'(s3_sums.sq_sum[SSP-1:0]);

  // Stage 4: partial products registered.
  logic                          s4_last;
  logic                          s4_sat;
  logic signed [GB-1:0]          s4_gradient;
  logic signed [WEIGHT_BITS-1:0] s4_decayed;
  logic [PAW-1:0]                s4_p_abs_hi;
  logic [PAW-1:0]                s4_p_abs_lo;
  logic [PSW-1:0]                s4_p_sq_hi;
  logic [PSW-1:0]                s4_p_sq_lo;

  always_ff @(posedge clk) begin
    if (s4_ready) begin
      s4_last     <= s3_last;
      s4_sat      <= s3_sums.sat;
      s4_gradient <= s3_gradient;
      s4_decayed  <= s3_decayed;
      s4_p_abs_hi <= s3_p_abs_hi;
      s4_p_abs_lo <= s3_p_abs_lo;
      s4_p_sq_hi  <= s3_p_sq_hi;
      s4_p_sq_lo  <= s3_p_sq_lo;
    end
  end

  // Recombine into the L1 term and the halved, truncated L2 term.
  logic [T1W-1:0]  s4_t1;
  logic [SQPW-1:0] s4_sq_full;
  logic [T2W-1:0]  s4_t2;

  assign s4_t1      = (T1W'(s4_p_abs_hi) << ASP) + T1W'(s4_p_abs_lo);
  assign s4_sq_full = (SQPW'(s4_p_sq_hi) << SSP) + SQPW'(s4_p_sq_lo);
  assign s4_t2      = s4_sq_full[SQPW-1:L2S];

  // Stage 5: loss terms registered.
  logic                          s5_last;
  logic                          s5_sat;
  logic signed [GB-1:0]          s5_gradient;
  logic signed [WEIGHT_BITS-1:0] s5_decayed;
  logic [T1W-1:0]                s5_t1;
  logic [T2W-1:0]                s5_t2;

  always_ff @(posedge clk) begin
    if (s5_ready) begin
      s5_last     <= s4_last;
      s5_sat      <= s4_sat;
      s5_gradient <= s4_gradient;
      s5_decayed  <= s4_decayed;
      s5_t1       <= s4_t1;
      s5_t2       <= s4_t2;
    end
  end

  // Saturating loss sum; the loss field is zero on items that are not last.
  logic [LSW-1:0] s5_loss_sum;
  logic           s5_loss_ovf;
  logic [LB-1:0]  s5_loss;

  assign s5_loss_sum = LSW'(s5_t1) + LSW'(s5_t2);
  assign s5_loss_ovf = s5_loss_sum > LOSS_CAP;

  always_comb begin
    if (!s5_last) begin
      s5_loss = '0;
    end else if (s5_loss_ovf) begin
      s5_loss = LOSS_CAP[LB-1:0];
    end else begin
      s5_loss = s5_loss_sum[LB-1:0];
    end
  end

  // Stage 6: output register.
  logic                          s6_last;
  logic                          s6_sat;
  logic signed [GB-1:0]          s6_gradient;
  logic signed [WEIGHT_BITS-1:0] s6_decayed;
  logic [LB-1:0]                 s6_set_loss;

  always_ff @(posedge clk) begin
    if (s6_ready) begin
      s6_last     <= s5_last;
      s6_sat      <= s5_sat | (s5_last & s5_loss_ovf);
      s6_gradient <= s5_gradient;
      s6_decayed  <= s5_decayed;
      s6_set_loss <= s5_loss;
    end
  end

  assign results.valid          = s6_valid;
  assign results.gradient       = s6_gradient;
  assign results.decayed_weight = s6_decayed;
  assign results.set_loss       = s6_set_loss;
  assign results.loss_valid     = s6_last;
  assign results.sum_saturated  = s6_sat;

  `ASSERT_IMPLIES(a_ready_when_empty, clk, rst, !s1_valid, weights.ready)
  `ASSERT_IMPLIES(a_loss_only_on_last, clk, rst, s6_valid && !s6_last, s6_set_loss == '0)
  `ASSERT_NEXT(a_result_held, clk, rst, s6_valid && !results.ready, s6_valid && $stable(s6_gradient))

endmodule

`default_nettype wire
